// ----- sv/mvc_pkg.sv -----
// ----------------------------------------------------------------------------
// mvc_pkg: shared types and constants
// Word layouts, register indexes, motion codes and wiring codes used by the
// motorized valve controller.
// ----------------------------------------------------------------------------
package mvc_pkg;

  localparam int TRAVEL_W   = 24;
  localparam int PAUSE_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int MOTION_W   = 3;

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = {TRAVEL_W{1'b1}};
  localparam logic [PAUSE_W-1:0]  PAUSE_MAX  = {PAUSE_W{1'b1}};

  localparam logic [TRAVEL_W-1:0] OPEN_TRAVEL_RST  = 24'd7000;
  localparam logic [TRAVEL_W-1:0] CLOSE_TRAVEL_RST = 24'd7000;
  localparam logic [PAUSE_W-1:0]  REV_PAUSE_RST    = 16'd250;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TRAVEL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TRAVEL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REV_PAUSE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MISSED  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_SW_PRES = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_SW_PRES = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SW_ACT_LOW   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_WIRING = 4'd7;

  // Motor wiring codes
  localparam logic [1:0] WIRING_NONE   = 2'd0;
  localparam logic [1:0] WIRING_SINGLE = 2'd1;
  localparam logic [1:0] WIRING_DUAL   = 2'd2;

  // Operation codes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Motion codes as reported on the result word
  localparam logic [MOTION_W-1:0] MOTION_IDLE       = 3'd0;
  localparam logic [MOTION_W-1:0] MOTION_WAIT_OPEN  = 3'd1;
  localparam logic [MOTION_W-1:0] MOTION_WAIT_CLOSE = 3'd2;
  localparam logic [MOTION_W-1:0] MOTION_OPENING    = 3'd3;
  localparam logic [MOTION_W-1:0] MOTION_CLOSING    = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE       = 5'b00001,
    MODE_WAIT_OPEN  = 5'b00010,
    MODE_WAIT_CLOSE = 5'b00100,
    MODE_OPENING    = 5'b01000,
    MODE_CLOSING    = 5'b10000
  } mvc_mode_t;

  typedef struct packed {
    logic operation;
    logic open_request;
    logic open_switch_level;
    logic close_switch_level;
  } mvc_in_t;

  typedef struct packed {
    logic                drive_open;
    logic                drive_close;
    logic [MOTION_W-1:0] motion;
    logic                valve_open;
    logic                motor_problem;
    logic                target_open;
  } mvc_out_t;

  typedef struct packed {
    logic [TRAVEL_W-1:0] open_travel_ms;
    logic [TRAVEL_W-1:0] close_travel_ms;
    logic [PAUSE_W-1:0]  reverse_pause_ms;
    logic                flag_missed_limit;
    logic                open_switch_present;
    logic                close_switch_present;
    logic                switch_active_low;
    logic [1:0]          motor_wiring;
  } mvc_cfg_t;

  function automatic logic [MOTION_W-1:0] mode_to_motion(input mvc_mode_t mode);
    logic [MOTION_W-1:0] code;
    unique case (mode)
      MODE_WAIT_OPEN:  code = MOTION_WAIT_OPEN;
      MODE_WAIT_CLOSE: code = MOTION_WAIT_CLOSE;
      MODE_OPENING:    code = MOTION_OPENING;
      MODE_CLOSING:    code = MOTION_CLOSING;
      default:         code = MOTION_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- sv/mvc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mvc_cfg_regs: configuration register file
// Holds the eight setup registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module mvc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0]   wr_data,
  output mvc_pkg::mvc_cfg_t                cfg
);
  import mvc_pkg::*;

  mvc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_travel_ms       <= OPEN_TRAVEL_RST;
      cfg_r.close_travel_ms      <= CLOSE_TRAVEL_RST;
      cfg_r.reverse_pause_ms     <= REV_PAUSE_RST;
      cfg_r.flag_missed_limit    <= 1'b0;
      cfg_r.open_switch_present  <= 1'b0;
      cfg_r.close_switch_present <= 1'b0;
      cfg_r.switch_active_low    <= 1'b0;
      cfg_r.motor_wiring         <= WIRING_SINGLE;
    end else if (wr_en) begin
      case (wr_index)
        REG_OPEN_TRAVEL:   cfg_r.open_travel_ms       <= wr_data[TRAVEL_W-1:0];
        REG_CLOSE_TRAVEL:  cfg_r.close_travel_ms      <= wr_data[TRAVEL_W-1:0];
        REG_REV_PAUSE:     cfg_r.reverse_pause_ms     <= wr_data[PAUSE_W-1:0];
        REG_FLAG_MISSED:   cfg_r.flag_missed_limit    <= wr_data[0];
        REG_OPEN_SW_PRES:  cfg_r.open_switch_present  <= wr_data[0];
        REG_CLOSE_SW_PRES: cfg_r.close_switch_present <= wr_data[0];
        REG_SW_ACT_LOW:    cfg_r.switch_active_low    <= wr_data[0];
        REG_MOTOR_WIRING:  cfg_r.motor_wiring         <= wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/mvc_step.sv -----
// ----------------------------------------------------------------------------
// mvc_step: valve state and per-word update
// Holds motion mode, position, problem flag and elapsed counters, and works
// out the state after one tick or command in a single pass.
// ----------------------------------------------------------------------------
module mvc_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  mvc_pkg::mvc_in_t   item,
  input  mvc_pkg::mvc_cfg_t  cfg,
  output mvc_pkg::mvc_out_t  result
);
  import mvc_pkg::*;

  mvc_mode_t           mode_r, mode_nxt;
  logic                pos_r, pos_nxt;
  logic                prob_r, prob_nxt;
  logic                req_r, req_nxt;
  logic [TRAVEL_W-1:0] travel_r, travel_nxt;
  logic [PAUSE_W-1:0]  pause_r, pause_nxt;

  logic                open_act, close_act;
  logic [TRAVEL_W-1:0] travel_inc;
  logic [PAUSE_W-1:0]  pause_inc;
  logic                moving_open;
  logic                move_act, move_pres;
  logic [TRAVEL_W-1:0] move_lim;
  logic                want_open;
  logic                prev_moving, same_dir, reversing;
  logic                wiring_ok;

  // Switch is active only when fitted and at its active level
  assign open_act  = cfg.open_switch_present &
                     (item.open_switch_level ^ cfg.switch_active_low);
  assign close_act = cfg.close_switch_present &
                     (item.close_switch_level ^ cfg.switch_active_low);

  assign travel_inc = (travel_r != TRAVEL_MAX) ? travel_r + 1'b1 : travel_r;
  assign pause_inc  = (pause_r != PAUSE_MAX) ? pause_r + 1'b1 : pause_r;

  assign moving_open = (mode_r == MODE_OPENING);
  assign move_act    = moving_open ? open_act : close_act;
  assign move_pres   = moving_open ? cfg.open_switch_present : cfg.close_switch_present;
  assign move_lim    = moving_open ? cfg.open_travel_ms : cfg.close_travel_ms;

  assign want_open   = item.open_request;
  assign prev_moving = (mode_r == MODE_OPENING) || (mode_r == MODE_CLOSING);
  assign same_dir    = (want_open && mode_r == MODE_OPENING) ||
                       (!want_open && mode_r == MODE_CLOSING);
  assign reversing   = (want_open && mode_r == MODE_CLOSING) ||
                       (!want_open && mode_r == MODE_OPENING);
  assign wiring_ok   = (cfg.motor_wiring == WIRING_SINGLE) ||
                       (cfg.motor_wiring == WIRING_DUAL);

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    prob_nxt   = prob_r;
    req_nxt    = req_r;
    travel_nxt = travel_r;
    pause_nxt  = pause_r;

    if (item.operation == OP_TICK) begin
      travel_nxt = travel_inc;
      pause_nxt  = pause_inc;
      if (open_act && close_act) begin
        // conflicting switches
        mode_nxt  = MODE_IDLE;
        pause_nxt = '0;
        prob_nxt  = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_WAIT_OPEN, MODE_WAIT_CLOSE: begin
            if (cfg.reverse_pause_ms == '0 || pause_inc >= cfg.reverse_pause_ms) begin
              mode_nxt   = (mode_r == MODE_WAIT_OPEN) ? MODE_OPENING : MODE_CLOSING;
              travel_nxt = '0;
              pause_nxt  = '0;
            end
          end
          MODE_OPENING, MODE_CLOSING: begin
            if (move_act) begin
              mode_nxt  = MODE_IDLE;
              pause_nxt = '0;
              pos_nxt   = moving_open;
              prob_nxt  = 1'b0;
            end else if (move_lim == '0 || travel_inc >= move_lim) begin
              mode_nxt  = MODE_IDLE;
              pause_nxt = '0;
              if (move_pres && cfg.flag_missed_limit) begin
                prob_nxt = 1'b1;
              end else begin
                pos_nxt  = moving_open;
                prob_nxt = 1'b0;
              end
            end
          end
          default: begin
            // idle: follow whichever switch is active
            if (open_act) begin
              pos_nxt = 1'b1;
            end else if (close_act) begin
              pos_nxt = 1'b0;
            end
          end
        endcase
      end
    end else begin
      req_nxt = want_open;
      priority if (!wiring_ok) begin
        prob_nxt = 1'b1;
      end else if ((want_open && open_act) || (!want_open && close_act)) begin
        // already at the target limit
        mode_nxt  = MODE_IDLE;
        pause_nxt = '0;
        pos_nxt   = want_open;
        prob_nxt  = 1'b0;
      end else if (same_dir) begin
        travel_nxt = '0;
      end else if (reversing && cfg.reverse_pause_ms != '0) begin
        mode_nxt  = want_open ? MODE_WAIT_OPEN : MODE_WAIT_CLOSE;
        pause_nxt = '0;
      end else begin
        mode_nxt   = want_open ? MODE_OPENING : MODE_CLOSING;
        travel_nxt = '0;
        pause_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 1'b0;
      prob_r   <= 1'b0;
      req_r    <= 1'b0;
      travel_r <= '0;
      pause_r  <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      prob_r   <= prob_nxt;
      req_r    <= req_nxt;
      travel_r <= travel_nxt;
      pause_r  <= pause_nxt;
    end
  end

  // Result reflects the state after this word
  always_comb begin
    result.drive_open    = 1'b0;
    result.drive_close   = 1'b0;
    if (cfg.motor_wiring == WIRING_SINGLE) begin
      result.drive_open = (mode_nxt == MODE_OPENING) || (mode_nxt == MODE_CLOSING);
    end else if (cfg.motor_wiring == WIRING_DUAL) begin
      result.drive_open  = (mode_nxt == MODE_OPENING);
      result.drive_close = (mode_nxt == MODE_CLOSING);
    end
    result.motion        = mode_to_motion(mode_nxt);
    result.valve_open    = pos_nxt;
    result.motor_problem = prob_nxt;
    result.target_open   = req_nxt;
  end

`ifndef NO_ASSERTIONS
  // A wait mode is only ever entered with the pause counter restarted
  a_wait_clears_pause: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && mode_nxt != mode_r &&
     (mode_nxt == MODE_WAIT_OPEN || mode_nxt == MODE_WAIT_CLOSE)) |=> (pause_r == '0))
    else $error("wait mode entered without pause reset");

  // Leaving a moving mode for idle always clears the pause counter
  a_stop_clears_pause: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && prev_moving && mode_nxt == MODE_IDLE) |=> (pause_r == '0))
    else $error("stop did not clear pause counter");

  // Without valid wiring a command leaves the motion untouched
  a_bad_wiring_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.operation == OP_COMMAND && !wiring_ok) |=> $stable(mode_r))
    else $error("command moved motor with no wiring");
`endif

endmodule

// ----- sv/motorized_valve_controller.sv -----
// ----------------------------------------------------------------------------
// motorized_valve_controller: valve motor sequencing top level
// Input word register, state update and result register for a motorized valve.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per 1 ms tick or open/close command, with the raw levels
//           of both limit switches. Accepted when in_valid and in_ready.
//   out_* : one result word per input word, giving drive lines, motion code,
//           estimated position, problem flag and the last requested position.
//   cfg_* : register writes (index 0..7, data right aligned); cfg_ready is
//           always high, writes to indexes 8..15 are dropped. Write only while
//           no word is in flight.
// Path: an accepted word sits in the input register while the state update
//   runs, then the result register is written and out_valid rises.
// Throughput: one word per cycle unless the receiver stalls; the single-pass
//   update between the input and result registers sets that rate.
// Reset (rst_n low, synchronous): motor idle, position closed, problem clear,
//   counters zero, registers at their defaults, both pipeline stages empty.
// Receiver stall: the result register holds; the input register still fills,
//   then in_ready drops until the result word is taken.
// ----------------------------------------------------------------------------
module motorized_valve_controller (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  mvc_pkg::mvc_in_t               in_data,

  output logic                           out_valid,
  input  logic                           out_ready,
  output mvc_pkg::mvc_out_t              out_data,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mvc_pkg::*;

  mvc_cfg_t cfg;

  // input word register
  logic     in_valid_r;
  mvc_in_t  in_data_r;

  // result word register
  logic     out_valid_r;
  mvc_out_t out_data_r;

  mvc_out_t step_result;
  logic     advance;

  // A word moves from the input register to the result register whenever the
  // result register is empty or being drained this cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign cfg_ready = 1'b1;

  mvc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mvc_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Two-wire drive never energizes both directions at once
  a_no_dual_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.drive_open && out_data_r.drive_close))
    else $error("open and close drives both active");

  // Every word taken from the input register lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word lost");

  // Close drive line agrees with the reported closing motion
  a_drive_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.drive_close) |-> (out_data_r.motion == MOTION_CLOSING))
    else $error("close drive without closing motion");

  // Input register never drops a word while the output is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |=> in_valid_r)
    else $error("input word dropped during stall");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: motorized valve controller testbench
// Sends tick and open/close command words with raw limit switch levels. Each
// accepted word runs through a local model of the valve sequencer. Every
// result word is then compared field by field with the oldest expectation.
// The register settings change between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
  import mvc_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 100;
  localparam int MAX_REPORTS = 40;
  localparam int SETTLE      = 4;

  // long reversal pause for the closing stretch
  localparam logic [PAUSE_W-1:0] LONG_PAUSE = 16'd200;

  // codes the package does not name
  localparam logic [1:0]           WIRING_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 4'd12;

  // directed plan row kinds
  localparam logic IS_WORD   = 1'b0;
  localparam logic IS_REG    = 1'b1;
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  mvc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mvc_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  motorized_valve_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Valve model state: settings copy plus sequencer state
  // --------------------------------------------------------------------------
  mvc_cfg_t            valve_cfg;
  logic [MOTION_W-1:0] valve_mode;
  logic                valve_pos;
  logic                valve_fault;
  logic                valve_target;
  logic [TRAVEL_W-1:0] travel_count;
  logic [PAUSE_W-1:0]  pause_count;

  mvc_out_t expected_words[$];
  int       mismatch_count = 0;
  int       words_checked  = 0;
  int       words_sent     = 0;
  int       settings_seen  = 0;
  bit       steady         = 1'b0;  // set: neither side idles
  longint   cycle_count    = 0;

  // --------------------------------------------------------------------------
  // Directed plan. Register rows are written after the pipe drains. Word rows
  // with TYPED carry a hand-read expectation; the rest use the model.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    mvc_in_t               word;
    logic                  typed;
    mvc_out_t              want;
  } plan_row_t;

  localparam int PLAN_ROWS = 34;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // reset settings: single wire, no switches fitted, 250 tick pause
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b0, 1'b0},
      TYPED, '{1'b0, 1'b0, MOTION_IDLE, 1'b0, 1'b0, 1'b0}},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b1, 1'b1},
      TYPED, '{1'b1, 1'b0, MOTION_OPENING, 1'b0, 1'b0, 1'b1}},
    // same direction again: travel restarts, nothing visible changes
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b0, 1'b1},
      TYPED, '{1'b1, 1'b0, MOTION_OPENING, 1'b0, 1'b0, 1'b1}},
    // reversal with a pause: wait close
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b1, 1'b0},
      TYPED, '{1'b0, 1'b0, MOTION_WAIT_CLOSE, 1'b0, 1'b0, 1'b0}},
    // command in a wait mode starts at once
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b0, 1'b0},
      TYPED, '{1'b1, 1'b0, MOTION_CLOSING, 1'b0, 1'b0, 1'b0}},
    // no motor wiring: command raises the problem flag, motion stays as it was
    '{IS_REG, REG_MOTOR_WIRING, 24'(WIRING_NONE), '0, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b1, 1'b1},
      TYPED, '{1'b0, 1'b0, MOTION_CLOSING, 1'b0, 1'b1, 1'b1}},
    '{IS_REG, REG_MOTOR_WIRING, 24'(WIRING_UNUSED), '0, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b0, 1'b1}, PREDICTED, '0},
    // two wire, both switches fitted, no pause, zero open travel
    '{IS_REG, REG_MOTOR_WIRING, 24'(WIRING_DUAL), '0, PREDICTED, '0},
    '{IS_REG, REG_OPEN_SW_PRES, 24'd1, '0, PREDICTED, '0},
    '{IS_REG, REG_CLOSE_SW_PRES, 24'd1, '0, PREDICTED, '0},
    '{IS_REG, REG_REV_PAUSE, 24'd0, '0, PREDICTED, '0},
    '{IS_REG, REG_OPEN_TRAVEL, 24'd0, '0, PREDICTED, '0},
    '{IS_REG, REG_FLAG_MISSED, 24'd1, '0, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b1, 1'b1}, PREDICTED, '0},     // conflict
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b1, 1'b1, 1'b0}, PREDICTED, '0},     // resync open
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b0, 1'b1}, PREDICTED, '0},     // resync closed
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b1, 1'b0}, PREDICTED, '0},  // already open
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b0, 1'b0}, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b0, 1'b0}, PREDICTED, '0},  // no-pause reverse
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b0, 1'b0}, PREDICTED, '0},     // missed limit
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b0, 1'b0}, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b0, 1'b1}, PREDICTED, '0},     // close switch hit
    // index past the register file is dropped
    '{IS_REG, REG_UNUSED, 24'hFFFFFF, '0, PREDICTED, '0},
    '{IS_REG, REG_SW_ACT_LOW, 24'd1, '0, PREDICTED, '0},
    '{IS_REG, REG_FLAG_MISSED, 24'd0, '0, PREDICTED, '0},
    '{IS_REG, REG_CLOSE_TRAVEL, 24'd2, '0, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b0, 1'b1, 1'b1}, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b1, 1'b1, 1'b1}, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b1, 1'b1}, PREDICTED, '0},     // travel ends
    '{IS_WORD, '0, '0, '{OP_TICK, 1'b0, 1'b0, 1'b0}, PREDICTED, '0},     // low = conflict
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b1, 1'b1}, PREDICTED, '0},
    '{IS_WORD, '0, '0, '{OP_COMMAND, 1'b1, 1'b0, 1'b1}, PREDICTED, '0}   // open switch
  };

  // --------------------------------------------------------------------------
  // Valve model
  // --------------------------------------------------------------------------
  function automatic void reset_valve();
    valve_cfg                      = '0;
    valve_cfg.open_travel_ms       = OPEN_TRAVEL_RST;
    valve_cfg.close_travel_ms      = CLOSE_TRAVEL_RST;
    valve_cfg.reverse_pause_ms     = REV_PAUSE_RST;
    valve_cfg.motor_wiring         = WIRING_SINGLE;
    valve_mode                     = MOTION_IDLE;
    valve_pos                      = 1'b0;
    valve_fault                    = 1'b0;
    valve_target                   = 1'b0;
    travel_count                   = '0;
    pause_count                    = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OPEN_TRAVEL:   valve_cfg.open_travel_ms       = data[TRAVEL_W-1:0];
      REG_CLOSE_TRAVEL:  valve_cfg.close_travel_ms      = data[TRAVEL_W-1:0];
      REG_REV_PAUSE:     valve_cfg.reverse_pause_ms     = data[PAUSE_W-1:0];
      REG_FLAG_MISSED:   valve_cfg.flag_missed_limit    = data[0];
      REG_OPEN_SW_PRES:  valve_cfg.open_switch_present  = data[0];
      REG_CLOSE_SW_PRES: valve_cfg.close_switch_present = data[0];
      REG_SW_ACT_LOW:    valve_cfg.switch_active_low    = data[0];
      REG_MOTOR_WIRING:  valve_cfg.motor_wiring         = data[1:0];
      default: ;
    endcase
  endfunction

  function automatic void stop_motor();
    valve_mode  = MOTION_IDLE;
    pause_count = '0;
  endfunction

  function automatic void start_motor(input logic to_open);
    valve_mode   = to_open ? MOTION_OPENING : MOTION_CLOSING;
    travel_count = '0;
    pause_count  = '0;
  endfunction

  function automatic void valve_tick(input logic oa, input logic ca);
    logic                moving_open;
    logic                reached;
    logic                fitted;
    logic [TRAVEL_W-1:0] limit;
    if (travel_count != TRAVEL_MAX) travel_count = travel_count + 1'b1;
    if (pause_count != PAUSE_MAX) pause_count = pause_count + 1'b1;
    if (oa && ca) begin
      stop_motor();
      valve_fault = 1'b1;
    end else begin
      case (valve_mode)
        MOTION_WAIT_OPEN, MOTION_WAIT_CLOSE: begin
          if (pause_count >= valve_cfg.reverse_pause_ms)
            start_motor(valve_mode == MOTION_WAIT_OPEN);
        end
        MOTION_OPENING, MOTION_CLOSING: begin
          moving_open = (valve_mode == MOTION_OPENING);
          reached     = moving_open ? oa : ca;
          limit       = moving_open ? valve_cfg.open_travel_ms : valve_cfg.close_travel_ms;
          fitted      = moving_open ? valve_cfg.open_switch_present
                                    : valve_cfg.close_switch_present;
          if (reached) begin
            stop_motor();
            valve_pos   = moving_open;
            valve_fault = 1'b0;
          end else if (travel_count >= limit) begin
            // travel time is over; a fitted switch that never fired is a fault when missed limits are flagged
            stop_motor();
            if (fitted && valve_cfg.flag_missed_limit) begin
              valve_fault = 1'b1;
            end else begin
              valve_pos   = moving_open;
              valve_fault = 1'b0;
            end
          end
        end
        default: begin
          if (oa) valve_pos = 1'b1;
          else if (ca) valve_pos = 1'b0;
        end
      endcase
    end
  endfunction

  function automatic void valve_command(input logic to_open, input logic oa,
                                        input logic ca);
    logic [MOTION_W-1:0] prior;
    prior        = valve_mode;
    valve_target = to_open;
    if (valve_cfg.motor_wiring != WIRING_SINGLE && valve_cfg.motor_wiring != WIRING_DUAL) begin
      valve_fault = 1'b1;
    end else if ((to_open && oa) || (!to_open && ca)) begin
      stop_motor();
      valve_pos   = to_open;
      valve_fault = 1'b0;
    end else if ((to_open && prior == MOTION_OPENING) ||
                 (!to_open && prior == MOTION_CLOSING)) begin
      travel_count = '0;
    end else if ((prior == MOTION_OPENING || prior == MOTION_CLOSING) &&
                 valve_cfg.reverse_pause_ms != '0) begin
      // any move left here is a reversal
      valve_mode  = to_open ? MOTION_WAIT_OPEN : MOTION_WAIT_CLOSE;
      pause_count = '0;
    end else begin
      start_motor(to_open);
    end
  endfunction

  function automatic mvc_out_t predict_valve(input mvc_in_t w);
    mvc_out_t res;
    logic     act_lvl;
    logic     oa;
    logic     ca;
    act_lvl = ~valve_cfg.switch_active_low;
    oa = valve_cfg.open_switch_present && (w.open_switch_level == act_lvl);
    ca = valve_cfg.close_switch_present && (w.close_switch_level == act_lvl);
    if (w.operation == OP_COMMAND) valve_command(w.open_request, oa, ca);
    else valve_tick(oa, ca);
    res = '0;
    if (valve_cfg.motor_wiring == WIRING_SINGLE) begin
      res.drive_open = (valve_mode == MOTION_OPENING || valve_mode == MOTION_CLOSING);
    end else if (valve_cfg.motor_wiring == WIRING_DUAL) begin
      res.drive_open  = (valve_mode == MOTION_OPENING);
      res.drive_close = (valve_mode == MOTION_CLOSING);
    end
    res.motion        = valve_mode;
    res.valve_open    = valve_pos;
    res.motor_problem = valve_fault;
    res.target_open   = valve_target;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 26);
  endfunction

  // Mostly commands that flip direction and ticks where the switch of the
  // side being driven to fires now and then; a few words carry random levels.
  function automatic mvc_in_t random_word();
    mvc_in_t w;
    logic    act_lvl;
    logic    hit;
    act_lvl        = ~valve_cfg.switch_active_low;
    w.operation    = ($urandom_range(99) < 14) ? OP_COMMAND : OP_TICK;
    w.open_request = ($urandom_range(3) != 0) ? ~valve_target : valve_target;
    if ($urandom_range(99) < 6) begin
      w.open_switch_level  = 1'($urandom);
      w.close_switch_level = 1'($urandom);
    end else begin
      hit = ($urandom_range(99) < 10);
      w.open_switch_level  = (hit && valve_target) ? act_lvl : ~act_lvl;
      w.close_switch_level = (hit && !valve_target) ? act_lvl : ~act_lvl;
    end
    return w;
  endfunction

  function automatic logic [TRAVEL_W-1:0] pick_travel();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 9) return TRAVEL_W'($urandom_range(TRAVEL_MAX, 1000));
    return TRAVEL_W'($urandom_range(30, 1));
  endfunction

  // in_valid stays high from here until the word is taken
  task automatic send_word(input mvc_in_t w, input logic typed, input mvc_out_t want);
    mvc_out_t predicted;
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_valve(w);
    expected_words.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // wait until every result is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  // phase 0: travel, pause and flags at their top; phase 1: all of them at zero
  task automatic program_phase(input int p);
    logic [TRAVEL_W-1:0]   open_t;
    logic [TRAVEL_W-1:0]   close_t;
    logic [PAUSE_W-1:0]    pause_t;
    logic [1:0]            wiring;
    logic [3:0]            flags;  // missed limit, open fitted, close fitted, active low
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if (p == 0) begin
      open_t  = TRAVEL_MAX;
      close_t = TRAVEL_MAX;
      pause_t = PAUSE_MAX;
      flags   = '1;
      wiring  = WIRING_DUAL;
    end else if (p == 1) begin
      open_t  = '0;
      close_t = '0;
      pause_t = '0;
      flags   = '0;
      wiring  = WIRING_SINGLE;
      junk    = '0;
    end else begin
      open_t  = pick_travel();
      close_t = pick_travel();
      pause_t = ($urandom_range(4) == 0) ? '0 : PAUSE_W'($urandom_range(12, 1));
      flags   = 4'($urandom);
      case ($urandom_range(9))
        0:          wiring = WIRING_NONE;
        1:          wiring = WIRING_UNUSED;
        2, 3, 4, 5: wiring = WIRING_SINGLE;
        default:    wiring = WIRING_DUAL;
      endcase
    end
    write_reg(REG_OPEN_TRAVEL, open_t);
    write_reg(REG_CLOSE_TRAVEL, close_t);
    write_reg(REG_REV_PAUSE, CFG_DATA_W'(pause_t));
    write_reg(REG_FLAG_MISSED, {junk[CFG_DATA_W-1:1], flags[3]});
    write_reg(REG_OPEN_SW_PRES, {junk[CFG_DATA_W-1:1], flags[2]});
    write_reg(REG_CLOSE_SW_PRES, {junk[CFG_DATA_W-1:1], flags[1]});
    write_reg(REG_SW_ACT_LOW, {junk[CFG_DATA_W-1:1], flags[0]});
    write_reg(REG_MOTOR_WIRING, {junk[CFG_DATA_W-1:2], wiring});
    write_reg(REG_UNUSED, junk);
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  task automatic check_word(input mvc_out_t want, input mvc_out_t got);
    words_checked++;
    if (got.drive_open !== want.drive_open)
      report_mismatch($sformatf("result %0d drive_open %b, want %b",
                                words_checked, got.drive_open, want.drive_open));
    if (got.drive_close !== want.drive_close)
      report_mismatch($sformatf("result %0d drive_close %b, want %b",
                                words_checked, got.drive_close, want.drive_close));
    if (got.motion !== want.motion)
      report_mismatch($sformatf("result %0d motion %0d, want %0d",
                                words_checked, got.motion, want.motion));
    if (got.valve_open !== want.valve_open)
      report_mismatch($sformatf("result %0d valve_open %b, want %b",
                                words_checked, got.valve_open, want.valve_open));
    if (got.motor_problem !== want.motor_problem)
      report_mismatch($sformatf("result %0d motor_problem %b, want %b",
                                words_checked, got.motor_problem, want.motor_problem));
    if (got.target_open !== want.target_open)
      report_mismatch($sformatf("result %0d target_open %b, want %b",
                                words_checked, got.target_open, want.target_open));
  endtask

  // out_ready and out_valid are both pre-edge values here
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) report_mismatch("result word with nothing expected");
      else check_word(expected_words.pop_front(), out_data);
    end
    out_ready <= rst_n && !idle_roll();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_words.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic after_reg;
    reset_valve();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    after_reg = 1'b0;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (DIRECTED_PLAN[r].is_reg) begin
        if (!after_reg) drain();
        write_reg(DIRECTED_PLAN[r].idx, DIRECTED_PLAN[r].data);
        after_reg = 1'b1;
      end else begin
        if (after_reg) cfg_valid <= 1'b0;
        send_word(DIRECTED_PLAN[r].word, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
        after_reg = 1'b0;
      end
    end
    settings_seen++;

    // random phases, one register setting each; phase 4 runs without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      program_phase(p);
      steady = (p == 4);
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), PREDICTED, '0);
      steady = 1'b0;
    end

    // long reversal pause: reverse, then tick through the whole count
    drain();
    write_reg(REG_REV_PAUSE, CFG_DATA_W'(LONG_PAUSE));
    write_reg(REG_OPEN_SW_PRES, '0);
    write_reg(REG_CLOSE_SW_PRES, '0);
    write_reg(REG_MOTOR_WIRING, CFG_DATA_W'(WIRING_SINGLE));
    cfg_valid <= 1'b0;
    settings_seen++;
    steady = 1'b1;
    send_word('{OP_COMMAND, 1'b1, 1'b0, 1'b0}, PREDICTED, '0);
    send_word('{OP_COMMAND, 1'b0, 1'b0, 1'b0}, PREDICTED, '0);
    for (int n = 0; n < int'(LONG_PAUSE) + 2; n++) begin
      send_word('{OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom)}, PREDICTED, '0);
    end
    steady = 1'b0;

    drain();
    $display("summary: %0d words sent, %0d results checked under %0d register settings",
             words_sent, words_checked, settings_seen);
    $display("summary: %0d field mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
